// ===== design/yuyv_to_argb_macros.svh =====
// Assertion macros for the YUYV to ARGB converter.
// Used by yuyv_to_argb.sv; expects clk and rst_n in scope.
`ifndef YUYV_TO_ARGB_MACROS_SVH
`define YUYV_TO_ARGB_MACROS_SVH

// Implication check, disabled during reset.
`define Y2A_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check, disabled during reset.
`define Y2A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/y2a_pkg.sv =====
// Package for the YUYV to ARGB converter: beat types, coefficients, clamp/pack.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package y2a_pkg;

    typedef struct packed {
        logic [7:0] first_luma;
        logic [7:0] blue_chroma;
        logic [7:0] second_luma;
        logic [7:0] red_chroma;
        logic       frame_last_in;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] first_pixel;
        logic [31:0] second_pixel;
        logic        frame_last_out;
    } out_beat_t;

    // BT.601 full range, 10 fractional bits
    localparam int          FracBits     = 10;
    localparam int          ProdWidth    = 19;
    localparam int          DeltaWidth   = ProdWidth - FracBits;
    localparam int          SumWidth     = 11;
    localparam logic [8:0]  ChromaOffset = 9'd128;
    localparam logic [11:0] CoefRv       = 12'd1435;
    localparam logic [11:0] CoefGu       = 12'd352;
    localparam logic [11:0] CoefGv       = 12'd731;
    localparam logic [11:0] CoefBu       = 12'd1815;
    localparam logic [7:0]  AlphaByte    = 8'hFF;

    function automatic logic [7:0] clamp8(input logic signed [SumWidth-1:0] x);
        logic [7:0] r;
        if (x < 0)
            r = 8'd0;
        else if (x > $signed(11'sd255))
            r = 8'hFF;
        else
            r = x[7:0];
        return r;
    endfunction

    function automatic logic [31:0] pack_pixel(
        input logic [7:0]                  y,
        input logic signed [DeltaWidth-1:0] dr,
        input logic signed [DeltaWidth-1:0] dg,
        input logic signed [DeltaWidth-1:0] db
    );
        logic signed [SumWidth-1:0] ys;
        logic signed [SumWidth-1:0] r;
        logic signed [SumWidth-1:0] g;
        logic signed [SumWidth-1:0] b;
        ys = $signed({{(SumWidth-8){1'b0}}, y});
        r  = ys + SumWidth'(dr);
        g  = ys - SumWidth'(dg);
        b  = ys + SumWidth'(db);
        return {AlphaByte, clamp8(r), clamp8(g), clamp8(b)};
    endfunction

endpackage

`default_nettype wire

// ===== design/yuyv_to_argb.sv =====
// YUYV macropixel to two ARGB8888 pixels, three-stage pipeline.
// Depends on y2a_pkg and yuyv_to_argb_macros.svh.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+-----------------------------
//   input   | pix_valid  | pix_stall  | pix_data  (y2a_pkg::in_beat_t)
//   output  | argb_valid | argb_stall | argb_data (y2a_pkg::out_beat_t)
//
// One beat per cycle when the output is not stalled; stages in order: chroma offset, multiply, sum/clamp.
// Each stage holds its beat while the stage after it is full and stalled,
// so pix_stall rises only when all three stages are occupied.
// Reset clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none

`include "yuyv_to_argb_macros.svh"

module yuyv_to_argb (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pix_valid,
    output logic                      pix_stall,
    input  wire y2a_pkg::in_beat_t    pix_data,
    output logic                      argb_valid,
    input  wire logic                 argb_stall,
    output y2a_pkg::out_beat_t        argb_data
);

    localparam int PW = y2a_pkg::ProdWidth;
    localparam int DW = y2a_pkg::DeltaWidth;
    localparam int MW = PW + 2;

    logic rdy1, rdy2, rdy3;

    // stage 1: remove chroma offset
    logic              s1_valid_reg, s1_valid_next;
    logic [7:0]        s1_y0_reg, s1_y1_reg;
    logic signed [8:0] s1_u_reg, s1_v_reg;
    logic              s1_last_reg;

    // stage 2: products
    logic                 s2_valid_reg, s2_valid_next;
    logic [7:0]           s2_y0_reg, s2_y1_reg;
    logic signed [PW-1:0] s2_r_reg, s2_g_reg, s2_b_reg;
    logic                 s2_last_reg;
    logic signed [MW-1:0] r_prod, g_prod, b_prod;

    // stage 3: output register
    logic                 argb_valid_reg, argb_valid_next;
    y2a_pkg::out_beat_t   argb_data_reg, argb_data_next;
    logic signed [DW-1:0] dr, dg, db;

    assign rdy3      = !argb_valid_reg || !argb_stall;
    assign rdy2      = !s2_valid_reg || rdy3;
    assign rdy1      = !s1_valid_reg || rdy2;
    assign pix_stall = !rdy1;

    assign s1_valid_next   = rdy1 ? pix_valid    : s1_valid_reg;
    assign s2_valid_next   = rdy2 ? s1_valid_reg : s2_valid_reg;
    assign argb_valid_next = rdy3 ? s2_valid_reg : argb_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            argb_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            argb_valid_reg <= argb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && pix_valid)
        begin
            s1_y0_reg   <= pix_data.first_luma;
            s1_y1_reg   <= pix_data.second_luma;
            s1_u_reg    <= $signed({1'b0, pix_data.blue_chroma} - y2a_pkg::ChromaOffset);
            s1_v_reg    <= $signed({1'b0, pix_data.red_chroma} - y2a_pkg::ChromaOffset);
            s1_last_reg <= pix_data.frame_last_in;
        end
    end

    always_comb
    begin
        r_prod = MW'(s1_v_reg) * $signed(MW'(y2a_pkg::CoefRv));
        g_prod = MW'(s1_u_reg) * $signed(MW'(y2a_pkg::CoefGu))
               + MW'(s1_v_reg) * $signed(MW'(y2a_pkg::CoefGv));
        b_prod = MW'(s1_u_reg) * $signed(MW'(y2a_pkg::CoefBu));
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid_reg)
        begin
            s2_y0_reg   <= s1_y0_reg;
            s2_y1_reg   <= s1_y1_reg;
            s2_r_reg    <= r_prod[PW-1:0];
            s2_g_reg    <= g_prod[PW-1:0];
            s2_b_reg    <= b_prod[PW-1:0];
            s2_last_reg <= s1_last_reg;
        end
    end

    // top bits of the product are the floor of x / 1024
    assign dr = s2_r_reg[PW-1:y2a_pkg::FracBits];
    assign dg = s2_g_reg[PW-1:y2a_pkg::FracBits];
    assign db = s2_b_reg[PW-1:y2a_pkg::FracBits];

    always_comb
    begin
        argb_data_next.first_pixel    = y2a_pkg::pack_pixel(s2_y0_reg, dr, dg, db);
        argb_data_next.second_pixel   = y2a_pkg::pack_pixel(s2_y1_reg, dr, dg, db);
        argb_data_next.frame_last_out = s2_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg)
            argb_data_reg <= argb_data_next;
    end

    assign argb_valid = argb_valid_reg;
    assign argb_data  = argb_data_reg;

    `Y2A_ASSERT(a_alpha_fixed, argb_valid, (argb_data.first_pixel[31:24] == y2a_pkg::AlphaByte) && (argb_data.second_pixel[31:24] == y2a_pkg::AlphaByte), "alpha byte not 0xFF")
    `Y2A_ASSERT(a_stall_only_full, pix_stall, s1_valid_reg && s2_valid_reg && argb_valid_reg, "input stalled with a free stage")
    `Y2A_ASSERT_NEXT(a_accept_lands, pix_valid && !pix_stall, s1_valid_reg, "accepted beat lost at stage 1")
    `Y2A_ASSERT_NEXT(a_s2_holds, s2_valid_reg && !rdy3, s2_valid_reg && $stable(s2_r_reg), "stage 2 beat dropped under stall")

endmodule

`default_nettype wire

// ===== test/yuyv_to_argb_checker.sv =====
// Scoreboard for the YUYV to ARGB converter: watches both channels, predicts each
// output beat from the accepted input beat and compares. Depends on y2a_pkg.
`timescale 1ns / 1ps

module yuyv_to_argb_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    input  logic               pix_stall,
    input  y2a_pkg::in_beat_t  pix_data,
    input  logic               argb_valid,
    input  logic               argb_stall,
    input  y2a_pkg::out_beat_t argb_data,
    output int                 mismatches,
    output int                 pending
);
    import y2a_pkg::*;

    out_beat_t pixels_due[$];
    int        bad_beats = 0;

    assign mismatches = bad_beats;

    initial
        pending = 0;

    function automatic logic [7:0] sat_byte(input int x);
        logic [7:0] r;
        if (x < 0)
            r = 8'd0;
        else if (x > 255)
            r = 8'd255;
        else
            r = x[7:0];
        return r;
    endfunction

    function automatic logic [31:0] argb_word(input int y, input int dr, input int dg,
                                              input int db);
        return {8'hFF, sat_byte(y + dr), sat_byte(y - dg), sat_byte(y + db)};
    endfunction

    // BT.601 full range, 10 fractional bits; >>> on int gives floor division
    function automatic out_beat_t argb_from_yuyv(input in_beat_t beat);
        out_beat_t o;
        int        u;
        int        v;
        int        dr;
        int        dg;
        int        db;
        u  = int'(beat.blue_chroma) - 128;
        v  = int'(beat.red_chroma) - 128;
        dr = (1435 * v) >>> 10;
        dg = (352 * u + 731 * v) >>> 10;
        db = (1815 * u) >>> 10;
        o.first_pixel    = argb_word(int'(beat.first_luma), dr, dg, db);
        o.second_pixel   = argb_word(int'(beat.second_luma), dr, dg, db);
        o.frame_last_out = beat.frame_last_in;
        return o;
    endfunction

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n)
        begin
            if (argb_valid && !argb_stall)
            begin
                if (pixels_due.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("ERROR: unexpected output beat %h", argb_data);
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (argb_data.first_pixel !== want.first_pixel
                        || argb_data.second_pixel !== want.second_pixel
                        || argb_data.frame_last_out !== want.frame_last_out)
                    begin
                        bad_beats++;
                        if (bad_beats <= 10)
                            $display("ERROR: pixels exp %h %h last %b, got %h %h last %b",
                                     want.first_pixel, want.second_pixel,
                                     want.frame_last_out, argb_data.first_pixel,
                                     argb_data.second_pixel, argb_data.frame_last_out);
                    end
                end
            end
            if (pix_valid && !pix_stall)
                pixels_due.push_back(argb_from_yuyv(pix_data));
        end
        pending = pixels_due.size();
    end

endmodule

// ===== test/yuyv_to_argb_tb.sv =====
// Testbench top for yuyv_to_argb: clock, reset, macropixel stimulus, output stall
// and verdict. Depends on y2a_pkg, yuyv_to_argb and yuyv_to_argb_checker.
`timescale 1ns / 1ps

module yuyv_to_argb_tb;
    import y2a_pkg::*;

    localparam int StallLimit = 3000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      pix_valid = 1'b0;
    logic      pix_stall;
    in_beat_t  pix_data = '0;
    logic      argb_valid;
    logic      argb_stall = 1'b0;
    out_beat_t argb_data;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    yuyv_to_argb dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_data   (pix_data),
        .argb_valid (argb_valid),
        .argb_stall (argb_stall),
        .argb_data  (argb_data)
    );

    yuyv_to_argb_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_data   (pix_data),
        .argb_valid (argb_valid),
        .argb_stall (argb_stall),
        .argb_data  (argb_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
        argb_stall <= ($urandom_range(99) < recv_stall_pct);

    // watchdog: cycles with no beat moved on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && !pix_stall) || (argb_valid && !argb_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic in_beat_t macropixel(input logic [7:0] y0, input logic [7:0] u,
                                            input logic [7:0] y1, input logic [7:0] v,
                                            input logic last);
        in_beat_t b;
        b.first_luma    = y0;
        b.blue_chroma   = u;
        b.second_luma   = y1;
        b.red_chroma    = v;
        b.frame_last_in = last;
        return b;
    endfunction

    // called and returns at a falling edge
    task automatic send_macropixel(input in_beat_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= beat;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        in_beat_t b;
        for (int i = 0; i < count; i++)
        begin
            b = in_beat_t'({32'($urandom), 1'b0});
            // keep a share near neutral chroma so channels stay off the rails
            if ($urandom_range(3) == 0)
            begin
                b.blue_chroma = 8'($urandom_range(156, 100));
                b.red_chroma  = 8'($urandom_range(156, 100));
            end
            b.frame_last_in = ($urandom_range(15) == 0);
            send_macropixel(b);
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct  = 11;
        recv_stall_pct = 83;
        send_macropixel(macropixel(8'd0, 8'd128, 8'd0, 8'd128, 1'b0));
        send_macropixel(macropixel(8'd255, 8'd128, 8'd255, 8'd128, 1'b1));
        send_macropixel(macropixel(8'd0, 8'd0, 8'd255, 8'd0, 1'b0));
        send_macropixel(macropixel(8'd255, 8'd255, 8'd0, 8'd255, 1'b0));
        send_macropixel(macropixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1));
        send_macropixel(macropixel(8'd255, 8'd255, 8'd255, 8'd0, 1'b0));
        send_macropixel(macropixel(8'd128, 8'd255, 8'd128, 8'd128, 1'b0));
        send_macropixel(macropixel(8'd128, 8'd0, 8'd128, 8'd128, 1'b0));
        send_macropixel(macropixel(8'd128, 8'd128, 8'd128, 8'd255, 1'b0));
        send_macropixel(macropixel(8'd128, 8'd128, 8'd128, 8'd0, 1'b1));
        send_macropixel(macropixel(8'd16, 8'd128, 8'd235, 8'd128, 1'b0));
        // one step off neutral: small negative deltas must floor, not truncate
        send_macropixel(macropixel(8'd1, 8'd127, 8'd254, 8'd129, 1'b0));
        send_macropixel(macropixel(8'd0, 8'd129, 8'd255, 8'd127, 1'b0));
        send_macropixel(macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b1));
        send_macropixel(macropixel(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0));
        send_macropixel(macropixel(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1));

        // hold off until the pipeline has drained completely
        pix_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        send_random(620);
        send_idle_pct  = 83;
        recv_stall_pct = 11;
        send_random(620);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(610);
        pix_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/y2a_pkg.sv
design/yuyv_to_argb.sv
test/yuyv_to_argb_checker.sv
test/yuyv_to_argb_tb.sv
